/* hw/rtl/pfe_pkg.sv */
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_VARS    = 5;

    localparam int CFG_W  = 32;
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 3;
    localparam int SEL_W  = 3;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // divide works on the dividend shifted up by the fraction bits
    localparam int QUO_W = VALUE_WIDTH + FRAC_BITS;
    localparam int SUM_W = VALUE_WIDTH + 2;
    localparam int PRD_W = 2 * VALUE_WIDTH;
    localparam int MAG_W = (PRD_W - FRAC_BITS > QUO_W) ? PRD_W - FRAC_BITS : QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    localparam t_value VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [63:0] VAL_MAX64 = 64'(VAL_MAX);
    localparam logic signed [63:0] VAL_MIN64 = 64'(VAL_MIN);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIV_ZERO,
        ST_UNDERFLOW,
        ST_OVERFLOW
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CALC,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        AP_IDLE,
        AP_STEP,
        AP_FIN,
        AP_DONE
    } t_alu_phase;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    // clamp a register value into the stack value range
    function automatic t_value cfg_to_value(input logic signed [CFG_W-1:0] c);
        logic signed [63:0] w;
        w = 64'(c);
        if (w > VAL_MAX64) begin
            return VAL_MAX;
        end
        if (w < VAL_MIN64) begin
            return VAL_MIN;
        end
        return VALUE_WIDTH'(w);
    endfunction

    function automatic logic [OUT_W-1:0] value_to_out(input t_value v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

    // apply sign to a magnitude and saturate
    function automatic t_value from_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic big;
        big = |(mag >> (VALUE_WIDTH - 1));
        if (big) begin
            return neg ? VAL_MIN : VAL_MAX;
        end
        return neg ? VALUE_WIDTH'(0) - mag[VALUE_WIDTH-1:0] : mag[VALUE_WIDTH-1:0];
    endfunction

endpackage

/* hw/rtl/pfe_ram.sv */
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pfe_alu.sv */
`timescale 1ns / 1ps

module pfe_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_alu_req i_req,
    input  pfe_pkg::t_value   i_lhs,
    input  pfe_pkg::t_value   i_rhs,
    output logic              o_done,
    output pfe_pkg::t_value   o_result
);

    import pfe_pkg::*;

    t_alu_phase r_phase, n_phase;
    t_op        r_op;
    logic       r_neg;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_hi;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [QUO_W-1:0]       r_lo;
    t_value                 r_res;

    logic                   w_step;
    logic                   w_fin;
    logic [VALUE_WIDTH-1:0] w_lhs_mag;
    logic [VALUE_WIDTH-1:0] w_rhs_mag;
    logic [VALUE_WIDTH:0]   w_t;
    logic [SUM_W-1:0]       ad_a;
    logic [SUM_W-1:0]       ad_b;
    logic                   ad_sub;
    logic [SUM_W-1:0]       w_b_eff;
    logic [SUM_W-1:0]       w_sum;
    logic [PRD_W-1:0]       w_prod;
    logic [VALUE_WIDTH:0]   w_as;
    t_value                 w_fin_val;

    assign w_lhs_mag = i_lhs[VALUE_WIDTH-1] ? VALUE_WIDTH'(0) - i_lhs : i_lhs;
    assign w_rhs_mag = i_rhs[VALUE_WIDTH-1] ? VALUE_WIDTH'(0) - i_rhs : i_rhs;

    // partial remainder with the next dividend bit shifted in
    assign w_t    = {r_hi, r_lo[QUO_W-1]};
    assign w_prod = {r_hi, r_lo[VALUE_WIDTH-1:0]};
    assign w_as   = w_prod[VALUE_WIDTH:0] == '0 ? r_lo[VALUE_WIDTH:0] : r_lo[VALUE_WIDTH:0];

    always_comb begin
        case (r_op)
            OP_MUL: begin
                ad_a   = {2'b00, r_hi};
                ad_b   = r_lo[0] ? {2'b00, r_b} : '0;
                ad_sub = 1'b0;
            end
            OP_DIV: begin
                ad_a   = {1'b0, w_t};
                ad_b   = {2'b00, r_b};
                ad_sub = 1'b1;
            end
            OP_SUB: begin
                ad_a   = {{2{r_hi[VALUE_WIDTH-1]}}, r_hi};
                ad_b   = {{2{r_b[VALUE_WIDTH-1]}}, r_b};
                ad_sub = 1'b1;
            end
            default: begin
                ad_a   = {{2{r_hi[VALUE_WIDTH-1]}}, r_hi};
                ad_b   = {{2{r_b[VALUE_WIDTH-1]}}, r_b};
                ad_sub = 1'b0;
            end
        endcase
    end

    assign w_b_eff = ad_sub ? ~ad_b : ad_b;
    assign w_sum   = ad_a + w_b_eff + {{(SUM_W-1){1'b0}}, ad_sub};

    always_comb begin
        case (r_op)
            OP_MUL: w_fin_val = from_mag(r_neg, MAG_W'(w_prod[PRD_W-1:FRAC_BITS]));
            OP_DIV: w_fin_val = from_mag(r_neg, MAG_W'(r_lo));
            default: begin
                if (w_as[VALUE_WIDTH] != w_as[VALUE_WIDTH-1]) begin
                    w_fin_val = w_as[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
                end else begin
                    w_fin_val = w_as[VALUE_WIDTH-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= AP_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        case (r_phase)
            AP_IDLE: n_phase = i_req.start ? AP_STEP : AP_IDLE;
            AP_STEP: n_phase = (r_cnt == CNT_W'(1)) ? AP_FIN : AP_STEP;
            AP_FIN:  n_phase = AP_DONE;
            AP_DONE: n_phase = AP_IDLE;
            default: n_phase = AP_IDLE;
        endcase
    end

    always_comb begin
        w_step = (r_phase == AP_STEP);
        w_fin  = (r_phase == AP_FIN);
        o_done = (r_phase == AP_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == AP_IDLE && i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_lhs[VALUE_WIDTH-1] ^ i_rhs[VALUE_WIDTH-1];
            case (i_req.op)
                OP_MUL: begin
                    r_cnt <= CNT_W'(VALUE_WIDTH);
                    r_hi  <= '0;
                    r_b   <= w_rhs_mag;
                    r_lo  <= QUO_W'(w_lhs_mag);
                end
                OP_DIV: begin
                    r_cnt <= CNT_W'(QUO_W);
                    r_hi  <= '0;
                    r_b   <= w_rhs_mag;
                    r_lo  <= {w_lhs_mag, {FRAC_BITS{1'b0}}};
                end
                default: begin
                    r_cnt <= CNT_W'(1);
                    r_hi  <= i_lhs;
                    r_b   <= i_rhs;
                    r_lo  <= '0;
                end
            endcase
        end else if (w_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
            case (r_op)
                OP_MUL: begin
                    // add then shift the product pair right
                    r_hi <= w_sum[VALUE_WIDTH:1];
                    r_lo <= QUO_W'({w_sum[0], r_lo[VALUE_WIDTH-1:1]});
                end
                OP_DIV: begin
                    if (!w_sum[SUM_W-1]) begin
                        r_hi <= w_sum[VALUE_WIDTH-1:0];
                    end else begin
                        r_hi <= w_t[VALUE_WIDTH-1:0];
                    end
                    r_lo <= {r_lo[QUO_W-2:0], ~w_sum[SUM_W-1]};
                end
                default: begin
                    r_lo <= QUO_W'(w_sum[VALUE_WIDTH:0]);
                end
            endcase
        end else if (w_fin) begin
            r_res <= w_fin_val;
        end
    end

    assign o_result = r_res;

endmodule

/* hw/rtl/postfix_expression_evaluator.sv */
`timescale 1ns / 1ps
// A push, any error and any token while an error is latched go from decode
// straight to finish; add and subtract use the ALU adder directly, and multiply
// and divide the bit-serial shift-add/subtract loop, after the RAM operand read.
// One token at a time: ready returns when its result is registered, so a new token
// is not taken before the last one is through.
// Reset (synchronous, active low) clears stack level, error and variable registers.
module postfix_expression_evaluator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [pfe_pkg::SEL_W-1:0] i_var_select,
    input  logic [1:0]                i_op_code,
    input  logic                      i_last_token,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [pfe_pkg::OUT_W-1:0] o_top_value,
    output logic [1:0]                o_status,
    output logic                      o_done_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pfe_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pfe_pkg::CFG_W-1:0] i_cfg_data
);

    import pfe_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_var [NUM_VARS];
    logic             r_mode;
    logic [SEL_W-1:0] r_sel;
    t_op              r_op;
    logic             r_last;
    logic [LVL_W-1:0] r_level;
    t_status          r_err;
    t_value           r_top;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_top;
    t_status          r_out_status;
    logic             r_out_done;

    logic              w_accept;
    logic              w_full;
    logic              w_under;
    logic              w_divz;
    logic              w_go_alu;
    t_value            w_var_val;
    logic [LVL_W-1:0]  w_lvl_m2;
    logic [ADDR_W-1:0] w_lhs_addr;

    logic    w_push;
    logic    w_err_set;
    t_status w_err_code;
    logic    w_commit;
    logic    w_emit;

    t_alu_req          w_alu_req;
    logic              w_alu_done;
    t_value            w_alu_res;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    t_value            w_ram_wdata;
    t_value            w_ram_rdata;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_full   = (r_level >= LVL_W'(STACK_DEPTH));
    assign w_under  = (r_level < LVL_W'(2));
    assign w_divz   = (r_op == OP_DIV) && (r_top == '0);
    assign w_go_alu = (r_err == ST_OK) && r_mode && !w_under && !w_divz;

    assign w_lvl_m2   = r_level - LVL_W'(2);
    assign w_lhs_addr = w_lvl_m2[ADDR_W-1:0];

    assign w_var_val = (r_sel < SEL_W'(NUM_VARS)) ? cfg_to_value(r_var[r_sel]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = w_accept ? S_DECODE : S_IDLE;
            S_DECODE: n_state = w_go_alu ? S_READ : S_FINISH;
            S_READ:   n_state = S_CALC;
            S_CALC:   n_state = w_alu_done ? S_FINISH : S_CALC;
            S_FINISH: n_state = w_emit ? S_IDLE : S_FINISH;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_push     = 1'b0;
        w_err_set  = 1'b0;
        w_err_code = ST_OK;
        w_alu_req  = '{start: 1'b0, op: r_op};
        w_commit   = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DECODE: begin
                if (r_err == ST_OK) begin
                    if (!r_mode) begin
                        if (w_full) begin
                            w_err_set  = 1'b1;
                            w_err_code = ST_OVERFLOW;
                        end else begin
                            w_push = 1'b1;
                        end
                    end else if (w_under) begin
                        w_err_set  = 1'b1;
                        w_err_code = ST_UNDERFLOW;
                    end else if (w_divz) begin
                        w_err_set  = 1'b1;
                        w_err_code = ST_DIV_ZERO;
                    end
                end
            end
            S_READ: begin
                w_alu_req.start = 1'b1;
            end
            S_CALC: begin
                w_commit = w_alu_done;
            end
            S_FINISH: begin
                w_emit = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_ram_we    = w_push || w_commit;
    assign w_ram_waddr = w_push ? r_level[ADDR_W-1:0] : w_lhs_addr;
    assign w_ram_wdata = w_push ? w_var_val : w_alu_res;

    pfe_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_lhs_addr),
        .o_rdata(w_ram_rdata)
    );

    // top of stack lives in r_top, the deeper operand comes from the RAM
    pfe_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_lhs   (w_ram_rdata),
        .i_rhs   (r_top),
        .o_done  (w_alu_done),
        .o_result(w_alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_VARS; i++) begin
                r_var[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < IDX_W'(NUM_VARS)) begin
                r_var[i_cfg_index] <= i_cfg_data;
            end
            if (w_emit && r_last) begin
                r_level <= '0;
                r_err   <= ST_OK;
            end else begin
                if (w_push) begin
                    r_level <= r_level + LVL_W'(1);
                end else if (w_commit) begin
                    r_level <= r_level - LVL_W'(1);
                end
                if (w_err_set) begin
                    r_err <= w_err_code;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_sel  <= i_var_select;
            r_op   <= t_op'(i_op_code);
            r_last <= i_last_token;
        end
        if (w_push) begin
            r_top <= w_var_val;
        end else if (w_commit) begin
            r_top <= w_alu_res;
        end
        if (w_emit) begin
            r_out_top    <= (r_level != '0) ? value_to_out(r_top) : '0;
            r_out_status <= r_err;
            r_out_done   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_top_value = r_out_top;
    assign o_status    = r_out_status;
    assign o_done_res  = r_out_done;

endmodule

/* hw/rtl/pfe_checker.sv */
`timescale 1ns / 1ps

module pfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_top_value,
    input logic [1:0]  o_status,
    input logic        o_done_res
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_top_value)
            && $stable(o_status) && $stable(o_done_res))
        else $error("stalled result changed");

    // one token in flight: ready drops after each transfer
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("token taken while another is in flight");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after token transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not return to idle");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);
